/* rtl/core/cfbse_pkg.sv */
// shared types, codes and sprite table for the clipped fill / blit / cursor engine
package cfbse_pkg;

    localparam int            MAX_DIM     = 4096;
    localparam int            SPRITE_W    = 12;
    localparam int            SPRITE_H    = 19;
    localparam int            DIM_W       = 13;
    localparam int            COORD_W     = 12;
    localparam int            CFG_IDX_W   = 1;
    localparam int            QUEUE_DEPTH = 4;
    localparam int            QUEUE_AW    = 2;
    localparam int            QUEUE_CW    = 3;

    localparam logic [DIM_W-1:0] DIM_LIMIT    = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

    localparam logic [31:0] CURSOR_DARK  = 32'h0000_0000;
    localparam logic [31:0] CURSOR_LIGHT = 32'h00FF_FFFF;

    // input item kinds
    localparam logic [1:0] KIND_FILL   = 2'd0;
    localparam logic [1:0] KIND_BLIT   = 2'd1;
    localparam logic [1:0] KIND_CURSOR = 2'd2;
    localparam logic [1:0] KIND_TICK   = 2'd3;

    // running job modes
    localparam logic [1:0] MODE_FILL   = 2'd0;
    localparam logic [1:0] MODE_BLIT   = 2'd1;
    localparam logic [1:0] MODE_CURSOR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SURF_W = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SURF_H = 1'd1;

    // sprite cell codes
    localparam logic [1:0] CELL_CLEAR = 2'd0;
    localparam logic [1:0] CELL_DARK  = 2'd1;
    localparam logic [1:0] CELL_LIGHT = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] rect_width;
        logic signed [15:0] rect_height;
        logic [31:0]        color;
    } t_in;

    typedef struct packed {
        logic        write_valid;
        logic        from_source;
        logic [23:0] dest_offset;
        logic [29:0] src_offset;
        logic [31:0] pixel_value;
        logic        done_res;
        logic        busy_res;
        logic        accepted;
    } t_out;

    // classified request handed from the front to the back
    typedef struct packed {
        logic               wv;
        logic               from_src;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [DIM_W-1:0]   sw;
        logic [16:0]        srow;
        logic [16:0]        scol;
        logic [15:0]        pitch;
        logic [31:0]        pix;
        logic               done;
        logic               busy;
        logic               acc;
    } t_job;

    // one sprite row, leftmost cell in the top two bits
    function automatic logic [23:0] arrow_row(input logic [4:0] row);
        logic [23:0] bits;
        unique case (row)
            5'd0:  bits = 24'b01_00_00_00_00_00_00_00_00_00_00_00;
            5'd1:  bits = 24'b01_01_00_00_00_00_00_00_00_00_00_00;
            5'd2:  bits = 24'b01_10_01_00_00_00_00_00_00_00_00_00;
            5'd3:  bits = 24'b01_10_10_01_00_00_00_00_00_00_00_00;
            5'd4:  bits = 24'b01_10_10_10_01_00_00_00_00_00_00_00;
            5'd5:  bits = 24'b01_10_10_10_10_01_00_00_00_00_00_00;
            5'd6:  bits = 24'b01_10_10_10_10_10_01_00_00_00_00_00;
            5'd7:  bits = 24'b01_10_10_10_10_10_10_01_00_00_00_00;
            5'd8:  bits = 24'b01_10_10_10_10_10_10_10_01_00_00_00;
            5'd9:  bits = 24'b01_10_10_10_10_10_10_10_10_01_00_00;
            5'd10: bits = 24'b01_10_10_10_10_10_10_10_10_10_01_00;
            5'd11: bits = 24'b01_10_10_10_10_10_10_10_10_10_10_01;
            5'd12: bits = 24'b01_10_10_10_10_10_10_01_01_01_01_01;
            5'd13: bits = 24'b01_10_10_10_01_10_10_01_00_00_00_00;
            5'd14: bits = 24'b01_10_10_01_00_01_10_10_01_00_00_00;
            5'd15: bits = 24'b01_10_01_00_00_01_10_10_01_00_00_00;
            5'd16: bits = 24'b01_01_00_00_00_00_01_10_10_01_00_00;
            5'd17: bits = 24'b00_00_00_00_00_00_01_10_10_01_00_00;
            5'd18: bits = 24'b00_00_00_00_00_00_00_01_01_00_00_00;
            default: bits = '0;
        endcase
        return bits;
    endfunction

    function automatic logic [1:0] arrow_cell(input logic [4:0] row, input logic [3:0] col);
        logic [23:0] bits;
        logic [4:0]  lsb;
        bits = arrow_row(row);
        lsb  = 5'd22 - {col, 1'b0};
        if (col >= 4'(SPRITE_W)) return CELL_CLEAR;
        return bits[lsb +: 2];
    endfunction

endpackage

/* rtl/core/cfbse_front.sv */
// front end: config registers, command clipping, pixel walk and request classification
module cfbse_front
    import cfbse_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_req,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output t_job                 o_q_job
);

    logic [DIM_W-1:0] r_surf_w, r_surf_h;
    logic [1:0]       r_mode, n_mode;
    logic             r_running, n_running;
    logic [15:0]      r_origin_x, r_origin_y, r_span_w, r_span_h;
    logic [15:0]      n_origin_x, n_origin_y, n_span_w, n_span_h;
    logic [15:0]      r_col, r_row, n_col, n_row;
    logic [15:0]      r_src_x0, r_src_y0, r_src_pitch;
    logic [15:0]      n_src_x0, n_src_y0, n_src_pitch;
    logic [31:0]      r_fill, n_fill;

    logic             accept;
    logic [DIM_W-1:0] eff_w, eff_h;
    logic signed [17:0] sw18, sh18, x18, y18, w18, h18;
    logic signed [17:0] f_x1, f_y1, f_w1, f_h1, f_w2, f_h2;
    logic signed [17:0] b_x1, b_y1, b_w1, b_h1, b_w2, b_h2, b_sx, b_sy;
    logic             fill_ok, blit_ok, cur_ok, cmd_ok;
    logic signed [17:0] cur_px, cur_py;
    logic [1:0]       spr_code;
    logic             cur_write;
    logic [15:0]      col_inc, row_inc;
    t_job             job;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign o_q_push   = accept;
    assign o_q_job    = job;

    assign eff_w = (r_surf_w > DIM_LIMIT) ? DIM_LIMIT : r_surf_w;
    assign eff_h = (r_surf_h > DIM_LIMIT) ? DIM_LIMIT : r_surf_h;

    always_comb begin
        sw18 = signed'({5'b0, eff_w});
        sh18 = signed'({5'b0, eff_h});
        x18  = signed'({{2{i_in_req.pos_x[15]}}, i_in_req.pos_x});
        y18  = signed'({{2{i_in_req.pos_y[15]}}, i_in_req.pos_y});
        w18  = signed'({{2{i_in_req.rect_width[15]}}, i_in_req.rect_width});
        h18  = signed'({{2{i_in_req.rect_height[15]}}, i_in_req.rect_height});

        // fill: clip at the origin, then at the far edges
        f_x1 = (x18 < 18'sd0) ? 18'sd0 : x18;
        f_w1 = (x18 < 18'sd0) ? w18 + x18 : w18;
        f_y1 = (y18 < 18'sd0) ? 18'sd0 : y18;
        f_h1 = (y18 < 18'sd0) ? h18 + y18 : h18;
        f_w2 = (f_x1 + f_w1 > sw18) ? sw18 - f_x1 : f_w1;
        f_h2 = (f_y1 + f_h1 > sh18) ? sh18 - f_y1 : f_h1;
        fill_ok = (w18 > 18'sd0) && (h18 > 18'sd0) && (f_x1 < sw18) && (f_y1 < sh18)
                  && (f_w2 > 18'sd0) && (f_h2 > 18'sd0);

        // blit: a negative origin moves the source start inward
        b_sx = (x18 < 18'sd0) ? -x18 : 18'sd0;
        b_x1 = (x18 < 18'sd0) ? 18'sd0 : x18;
        b_w1 = (x18 < 18'sd0) ? w18 + x18 : w18;
        b_sy = (y18 < 18'sd0) ? -y18 : 18'sd0;
        b_y1 = (y18 < 18'sd0) ? 18'sd0 : y18;
        b_h1 = (y18 < 18'sd0) ? h18 + y18 : h18;
        b_w2 = (b_x1 + b_w1 > sw18) ? sw18 - b_x1 : b_w1;
        b_h2 = (b_y1 + b_h1 > sh18) ? sh18 - b_y1 : b_h1;
        blit_ok = (b_w2 > 18'sd0) && (b_h2 > 18'sd0);

        cur_ok = (x18 < sw18) && (y18 < sh18)
                 && (x18 + signed'(18'(SPRITE_W)) > 18'sd0)
                 && (y18 + signed'(18'(SPRITE_H)) > 18'sd0);

        // cursor cell for the current walk position
        cur_px = signed'({{2{r_origin_x[15]}}, r_origin_x} + {2'b00, r_col});
        cur_py = signed'({{2{r_origin_y[15]}}, r_origin_y} + {2'b00, r_row});
        spr_code = (r_row < 16'(SPRITE_H) && r_col < 16'(SPRITE_W))
                   ? arrow_cell(r_row[4:0], r_col[3:0]) : CELL_CLEAR;
        cur_write = (spr_code != CELL_CLEAR) && (cur_px >= 18'sd0) && (cur_py >= 18'sd0)
                    && (cur_px < sw18) && (cur_py < sh18);
        col_inc = r_col + 16'd1;
        row_inc = r_row + 16'd1;
    end

    always_comb begin
        n_mode      = r_mode;
        n_running   = r_running;
        n_origin_x  = r_origin_x;
        n_origin_y  = r_origin_y;
        n_span_w    = r_span_w;
        n_span_h    = r_span_h;
        n_col       = r_col;
        n_row       = r_row;
        n_src_x0    = r_src_x0;
        n_src_y0    = r_src_y0;
        n_src_pitch = r_src_pitch;
        n_fill      = r_fill;
        cmd_ok      = 1'b0;
        job         = '0;
        job.sw      = eff_w;

        if (i_in_req.kind == KIND_TICK) begin
            if (r_running) begin
                if (r_mode == MODE_CURSOR) begin
                    if (cur_write) begin
                        job.wv  = 1'b1;
                        job.dx  = cur_px[COORD_W-1:0];
                        job.dy  = cur_py[COORD_W-1:0];
                        job.pix = (spr_code == CELL_DARK) ? CURSOR_DARK : CURSOR_LIGHT;
                    end
                end else begin
                    job.wv = 1'b1;
                    job.dx = r_origin_x[COORD_W-1:0] + r_col[COORD_W-1:0];
                    job.dy = r_origin_y[COORD_W-1:0] + r_row[COORD_W-1:0];
                    if (r_mode == MODE_BLIT) begin
                        job.from_src = 1'b1;
                        job.srow     = {1'b0, r_src_y0} + {1'b0, r_row};
                        job.scol     = {1'b0, r_src_x0} + {1'b0, r_col};
                        job.pitch    = r_src_pitch;
                    end else begin
                        job.pix = r_fill;
                    end
                end
                n_col = col_inc;
                if (col_inc >= r_span_w) begin
                    n_col = '0;
                    n_row = row_inc;
                    if (row_inc >= r_span_h) begin
                        n_running = 1'b0;
                        job.done  = 1'b1;
                    end
                end
            end
        end else if (!r_running) begin
            priority if (i_in_req.kind == KIND_FILL) begin
                cmd_ok     = fill_ok;
                n_mode     = MODE_FILL;
                n_origin_x = f_x1[15:0];
                n_origin_y = f_y1[15:0];
                n_span_w   = f_w2[15:0];
                n_span_h   = f_h2[15:0];
                n_fill     = i_in_req.color;
            end else if (i_in_req.kind == KIND_BLIT) begin
                cmd_ok      = blit_ok;
                n_mode      = MODE_BLIT;
                n_origin_x  = b_x1[15:0];
                n_origin_y  = b_y1[15:0];
                n_span_w    = b_w2[15:0];
                n_span_h    = b_h2[15:0];
                n_src_x0    = b_sx[15:0];
                n_src_y0    = b_sy[15:0];
                n_src_pitch = i_in_req.rect_width;
            end else begin
                cmd_ok     = cur_ok;
                n_mode     = MODE_CURSOR;
                n_origin_x = i_in_req.pos_x;
                n_origin_y = i_in_req.pos_y;
                n_span_w   = 16'(SPRITE_W);
                n_span_h   = 16'(SPRITE_H);
            end
            if (cmd_ok) begin
                n_running = 1'b1;
                n_col     = '0;
                n_row     = '0;
            end
        end

        job.busy = n_running;
        job.acc  = cmd_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surf_w  <= RESET_WIDTH;
            r_surf_h  <= RESET_HEIGHT;
            r_running <= 1'b0;
            r_mode    <= MODE_FILL;
            r_col     <= '0;
            r_row     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SURF_W: r_surf_w <= i_cfg_data;
                    CFG_SURF_H: r_surf_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_running <= n_running;
                r_mode    <= n_mode;
                r_col     <= n_col;
                r_row     <= n_row;
            end
        end
    end

    // job geometry, only read while a command runs
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_origin_x  <= n_origin_x;
            r_origin_y  <= n_origin_y;
            r_span_w    <= n_span_w;
            r_span_h    <= n_span_h;
            r_src_x0    <= n_src_x0;
            r_src_y0    <= n_src_y0;
            r_src_pitch <= n_src_pitch;
            r_fill      <= n_fill;
        end
    end

endmodule

/* rtl/core/cfbse_queue.sv */
// short request queue between the front and the back
module cfbse_queue
    import cfbse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_data
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

`ifndef SYNTHESIS
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push && !do_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not follow a push");
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop && !do_push |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count did not follow a pop");
`endif

endmodule

/* rtl/core/cfbse_back.sv */
// back end: offset multiply stage and result register
module cfbse_back
    import cfbse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_job i_q_job,
    output logic o_q_pop,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_res
);

    logic        r1_valid;
    t_job        r1_job;
    logic [24:0] r1_dprod;
    logic [32:0] r1_sprod;
    logic        r_out_valid;
    t_out        r_out;
    logic        s1_ready, s2_ready;

    assign s2_ready    = !r_out_valid || !i_out_stall;
    assign s1_ready    = !r1_valid || s2_ready;
    assign o_q_pop     = i_q_valid && s1_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) r1_valid <= i_q_valid;
            if (s2_ready) r_out_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_q_valid) begin
            r1_job   <= i_q_job;
            r1_dprod <= i_q_job.dy * i_q_job.sw;
            r1_sprod <= i_q_job.srow * i_q_job.pitch;
        end
        if (s2_ready && r1_valid) begin
            r_out.write_valid <= r1_job.wv;
            r_out.from_source <= r1_job.from_src;
            r_out.dest_offset <= r1_dprod[23:0] + 24'(r1_job.dx);
            r_out.src_offset  <= r1_sprod[29:0] + 30'(r1_job.scol);
            r_out.pixel_value <= r1_job.pix;
            r_out.done_res    <= r1_job.done;
            r_out.busy_res    <= r1_job.busy;
            r_out.accepted    <= r1_job.acc;
        end
    end

`ifndef SYNTHESIS
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.write_valid |->
            r_out.dest_offset == '0 && r_out.src_offset == '0
            && r_out.pixel_value == '0 && !r_out.from_source)
        else $error("result without a write carries nonzero payload");
    a_hold_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_valid && !s2_ready |=> r1_valid && $stable(r1_job) && $stable(r1_dprod))
        else $error("multiply stage changed while blocked");
`endif

endmodule

/* rtl/core/clipped_fill_blit_sprite_engine_top.sv */
// top level of the clipped fill, blit and cursor drawing engine
//
// Request channel: i_in_valid / o_in_stall carry one t_in per request. Commands
// (fill, blit, cursor) start a job when idle and visible; each tick request walks
// one pixel of the running job in row-major order.
// Result channel: o_out_valid / i_out_stall carry one t_out for every request,
// in request order: destination offset plus colour or source offset, with done,
// busy and accepted flags.
// Config: i_cfg_we writes surface width (index 0) or height (index 1); write only
// while no request is in flight.
// Throughput: one request per clock while o_in_stall is low; the clip and walk logic
// in the front end is combinational. A result is registered through the queue entry,
// the multiply stage and then the result register.
// Reset: surface is 640 x 480, no job runs, queue and back end are empty.
// Result stall: the back end and a four-entry queue absorb it; o_in_stall rises
// once the queue is full and drops as soon as the back end drains an entry.
module clipped_fill_blit_sprite_engine_top
    import cfbse_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    logic q_full, q_push, q_valid, q_pop;
    t_job q_in_job, q_out_job;

    cfbse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_job    (q_in_job)
    );

    cfbse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out_job)
    );

    cfbse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_out_job),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

endmodule

/* tb/testbench.sv */
// self-checking testbench for the clipped fill, blit and cursor drawing engine
`timescale 1ns / 100ps

module testbench;
    import cfbse_pkg::*;

    typedef struct packed {
        t_in         req;
        logic [15:0] reps;
        logic        fixed;
        t_out        res;
    } t_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_req    = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_res;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = CFG_SURF_W;
    logic [DIM_W-1:0]     i_cfg_data  = '0;

    clipped_fill_blit_sprite_engine_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // drawing state as the engine should hold it
    logic [DIM_W-1:0] surf_w_reg = RESET_WIDTH;
    logic [DIM_W-1:0] surf_h_reg = RESET_HEIGHT;
    logic [1:0]       job_mode   = MODE_FILL;
    logic             job_active = 1'b0;
    logic [15:0]      org_x = '0, org_y = '0, run_w = '0, run_h = '0;
    logic [15:0]      col_n = '0, row_n = '0;
    logic [15:0]      src_col0 = '0, src_row0 = '0, src_stride = '0;
    logic [31:0]      fill_rgb = '0;

    t_out pending_writes[$];
    int   mismatches = 0;
    int   send_pct   = 0;
    int   recv_pct   = 0;
    logic hand_typed = 1'b0;
    t_out hand_res   = '0;

    // arrow shape: {opaque mask, light mask}, column 0 in the top bit of each half
    function automatic logic [23:0] arrow_masks(input logic [4:0] row);
        case (row)
            5'd0:  return {12'b1000_0000_0000, 12'b0000_0000_0000};
            5'd1:  return {12'b1100_0000_0000, 12'b0000_0000_0000};
            5'd2:  return {12'b1110_0000_0000, 12'b0100_0000_0000};
            5'd3:  return {12'b1111_0000_0000, 12'b0110_0000_0000};
            5'd4:  return {12'b1111_1000_0000, 12'b0111_0000_0000};
            5'd5:  return {12'b1111_1100_0000, 12'b0111_1000_0000};
            5'd6:  return {12'b1111_1110_0000, 12'b0111_1100_0000};
            5'd7:  return {12'b1111_1111_0000, 12'b0111_1110_0000};
            5'd8:  return {12'b1111_1111_1000, 12'b0111_1111_0000};
            5'd9:  return {12'b1111_1111_1100, 12'b0111_1111_1000};
            5'd10: return {12'b1111_1111_1110, 12'b0111_1111_1100};
            5'd11: return {12'b1111_1111_1111, 12'b0111_1111_1110};
            5'd12: return {12'b1111_1111_1111, 12'b0111_1110_0000};
            5'd13: return {12'b1111_1111_0000, 12'b0111_0110_0000};
            5'd14: return {12'b1111_0111_1000, 12'b0110_0011_0000};
            5'd15: return {12'b1110_0111_1000, 12'b0100_0011_0000};
            5'd16: return {12'b1100_0011_1100, 12'b0000_0001_1000};
            5'd17: return {12'b0000_0011_1100, 12'b0000_0001_1000};
            5'd18: return {12'b0000_0001_1000, 12'b0000_0000_0000};
            default: return '0;
        endcase
    endfunction

    function automatic int clamp_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(MAX_DIM)) ? MAX_DIM : int'(v);
    endfunction

    function automatic void launch_job(input logic [1:0] m, input int x, input int y,
                                       input int w, input int h);
        job_mode   = m;
        job_active = 1'b1;
        org_x      = 16'(x);
        org_y      = 16'(y);
        run_w      = 16'(w);
        run_h      = 16'(h);
        col_n      = '0;
        row_n      = '0;
    endfunction

    function automatic logic try_fill(input int x0, input int y0, input int w0, input int h0,
                                      input logic [31:0] c);
        int sw, sh, x, y, w, h;
        sw = clamp_dim(surf_w_reg);
        sh = clamp_dim(surf_h_reg);
        x = x0; y = y0; w = w0; h = h0;
        if (w <= 0 || h <= 0) return 1'b0;
        if (x < 0) begin
            w = w + x;
            x = 0;
        end
        if (y < 0) begin
            h = h + y;
            y = 0;
        end
        if (x >= sw || y >= sh) return 1'b0;
        if (x + w > sw) w = sw - x;
        if (y + h > sh) h = sh - y;
        if (w <= 0 || h <= 0) return 1'b0;
        launch_job(MODE_FILL, x, y, w, h);
        fill_rgb = c;
        return 1'b1;
    endfunction

    function automatic logic try_blit(input int x0, input int y0, input int w0, input int h0);
        int sw, sh, x, y, w, h, sx, sy;
        sw = clamp_dim(surf_w_reg);
        sh = clamp_dim(surf_h_reg);
        x = x0; y = y0; w = w0; h = h0;
        sx = 0; sy = 0;
        if (x < 0) begin
            sx = -x;
            w  = w + x;
            x  = 0;
        end
        if (y < 0) begin
            sy = -y;
            h  = h + y;
            y  = 0;
        end
        if (x + w > sw) w = sw - x;
        if (y + h > sh) h = sh - y;
        if (w <= 0 || h <= 0) return 1'b0;
        launch_job(MODE_BLIT, x, y, w, h);
        src_col0   = 16'(sx);
        src_row0   = 16'(sy);
        src_stride = 16'(w0);
        return 1'b1;
    endfunction

    function automatic logic try_cursor(input int x, input int y);
        int sw, sh;
        sw = clamp_dim(surf_w_reg);
        sh = clamp_dim(surf_h_reg);
        if (x >= sw || y >= sh || x + SPRITE_W <= 0 || y + SPRITE_H <= 0) return 1'b0;
        launch_job(MODE_CURSOR, x, y, SPRITE_W, SPRITE_H);
        return 1'b1;
    endfunction

    function automatic t_out pixel_write();
        t_out        r;
        longint      sw;
        int          sh, px, py, c;
        logic [23:0] art;
        r  = '0;
        sw = longint'(clamp_dim(surf_w_reg));
        sh = clamp_dim(surf_h_reg);
        if (job_mode == MODE_CURSOR) begin
            px = int'($signed(org_x)) + int'(col_n);
            py = int'($signed(org_y)) + int'(row_n);
            c  = int'(col_n);
            if (row_n < 16'(SPRITE_H) && col_n < 16'(SPRITE_W)) begin
                art = arrow_masks(row_n[4:0]);
                // off-surface or transparent cells still use up a tick
                if (art[23 - c] && px >= 0 && py >= 0 && px < int'(sw) && py < sh) begin
                    r.write_valid = 1'b1;
                    r.dest_offset = 24'(longint'(py) * sw + longint'(px));
                    r.pixel_value = art[11 - c] ? CURSOR_LIGHT : CURSOR_DARK;
                end
            end
            return r;
        end
        r.write_valid = 1'b1;
        r.dest_offset = 24'((longint'(org_y) + longint'(row_n)) * sw
                            + longint'(org_x) + longint'(col_n));
        if (job_mode == MODE_BLIT) begin
            r.from_source = 1'b1;
            r.src_offset  = 30'((longint'(src_row0) + longint'(row_n)) * longint'(src_stride)
                                + longint'(src_col0) + longint'(col_n));
        end else begin
            r.pixel_value = fill_rgb;
        end
        return r;
    endfunction

    function automatic t_out predict_result(input t_in q);
        t_out r;
        logic ok;
        r  = '0;
        ok = 1'b0;
        if (q.kind == KIND_TICK) begin
            if (job_active) begin
                r = pixel_write();
                col_n = col_n + 16'd1;
                if (col_n >= run_w) begin
                    col_n = '0;
                    row_n = row_n + 16'd1;
                    if (row_n >= run_h) begin
                        job_active = 1'b0;
                        r.done_res = 1'b1;
                    end
                end
            end
        end else if (!job_active) begin
            case (q.kind)
                KIND_FILL: ok = try_fill(int'($signed(q.pos_x)), int'($signed(q.pos_y)),
                                         int'($signed(q.rect_width)),
                                         int'($signed(q.rect_height)), q.color);
                KIND_BLIT: ok = try_blit(int'($signed(q.pos_x)), int'($signed(q.pos_y)),
                                         int'($signed(q.rect_width)),
                                         int'($signed(q.rect_height)));
                default:   ok = try_cursor(int'($signed(q.pos_x)), int'($signed(q.pos_y)));
            endcase
        end
        r.busy_res = job_active;
        r.accepted = ok;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 100)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_out want;
        t_out got;
        if (o_out_valid === 1'b1 && !i_out_stall) begin
            got = o_out_res;
            if (pending_writes.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing pending, expected none, actual 0x%0h",
                         $time, got);
            end else begin
                want = pending_writes.pop_front();
                check_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
                check_field("from_source", 32'(want.from_source), 32'(got.from_source));
                check_field("dest_offset", 32'(want.dest_offset), 32'(got.dest_offset));
                check_field("src_offset",  32'(want.src_offset),  32'(got.src_offset));
                check_field("pixel_value", want.pixel_value,      got.pixel_value);
                check_field("done_res",    32'(want.done_res),    32'(got.done_res));
                check_field("busy_res",    32'(want.busy_res),    32'(got.busy_res));
                check_field("accepted",    32'(want.accepted),    32'(got.accepted));
            end
        end
        if (i_in_valid && o_in_stall === 1'b0) begin
            want = predict_result(i_in_req);
            if (hand_typed) want = hand_res;
            pending_writes.push_back(want);
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= (int'($urandom_range(0, 99)) < recv_pct);
    end

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic drive_req(input t_in q, input logic fixed, input t_out res);
        while (int'($urandom_range(0, 99)) < send_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= q;
        hand_typed <= fixed;
        hand_res   <= res;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_writes.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_surface(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SURF_W;
        i_cfg_data <= w;
        surf_w_reg = w;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_SURF_H;
        i_cfg_data <= h;
        surf_h_reg = h;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in random_fields();
        t_in q;
        q.kind        = 2'($urandom);
        q.pos_x       = 16'($urandom);
        q.pos_y       = 16'($urandom);
        q.rect_width  = 16'($urandom);
        q.rect_height = 16'($urandom);
        q.color       = $urandom;
        return q;
    endfunction

    // coordinates cluster around both edges of the surface
    function automatic int edge_coord(input int ext);
        case ($urandom_range(0, 4))
            0:       return -int'($urandom_range(0, 14));
            1:       return ext - int'($urandom_range(0, 14));
            2:       return int'($urandom_range(0, (ext > 0) ? ext - 1 : 0));
            3:       return 0;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    // huge spans only where the surface is narrow enough to keep jobs short
    function automatic int span_len(input int ext);
        case ($urandom_range(0, 5))
            3:       return int'($urandom_range(0, 3)) - 2;
            4:       return (ext <= 40) ? 32767 - int'($urandom_range(0, 2))
                                        : int'($urandom_range(1, 10));
            5:       return -32768 + int'($urandom_range(0, 2));
            default: return int'($urandom_range(1, 10));
        endcase
    endfunction

    function automatic t_in shaped_command();
        t_in q;
        int  sw, sh, x, y, w, h, pick;
        q    = random_fields();
        sw   = clamp_dim(surf_w_reg);
        sh   = clamp_dim(surf_h_reg);
        pick = int'($urandom_range(0, 19));
        q.kind = (pick < 3) ? KIND_CURSOR : (pick < 11) ? KIND_FILL : KIND_BLIT;
        x = edge_coord(sw);
        y = edge_coord(sh);
        w = span_len(sw);
        h = span_len(sh);
        if (q.kind == KIND_BLIT) begin
            // far-off source origin with a few visible columns or rows
            if ($urandom_range(0, 3) == 0) begin
                x = -int'($urandom_range(100, 32700));
                w = -x + int'($urandom_range(0, 12)) - 2;
            end
            if ($urandom_range(0, 3) == 0) begin
                y = -int'($urandom_range(100, 32700));
                h = -y + int'($urandom_range(0, 12)) - 2;
            end
        end
        q.pos_x       = 16'(x);
        q.pos_y       = 16'(y);
        q.rect_width  = 16'(w);
        q.rect_height = 16'(h);
        return q;
    endfunction

    task automatic random_phase(input int n_items);
        int   counted;
        logic live;
        t_in  q;
        counted = 0;
        while (counted < n_items) begin
            live = job_active;
            if (live) begin
                q = random_fields();
                if ($urandom_range(0, 11) != 0) q.kind = KIND_TICK;
                else q.kind = 2'($urandom_range(0, 2));
            end else if ($urandom_range(0, 9) == 0) begin
                q = random_fields();
                q.kind = KIND_TICK;
            end else begin
                q = shaped_command();
            end
            drive_req(q, 1'b0, '0);
            if ((q.kind == KIND_TICK) == live) counted++;
        end
    endtask

    function automatic t_row plan_row(input logic [1:0] kind, input int x, input int y,
                                      input int w, input int h, input longint c,
                                      input int reps, input logic fixed, input t_out res);
        t_row r;
        r.req.kind        = kind;
        r.req.pos_x       = 16'(x);
        r.req.pos_y       = 16'(y);
        r.req.rect_width  = 16'(w);
        r.req.rect_height = 16'(h);
        r.req.color       = 32'(c);
        r.reps            = 16'(reps);
        r.fixed           = fixed;
        r.res             = res;
        return r;
    endfunction

    function automatic t_out known(input int wv, input int dest,
                                   input longint pix, input int done,
                                   input int busy, input int acc);
        t_out r;
        r             = '0;
        r.write_valid = 1'(wv);
        r.dest_offset = 24'(dest);
        r.pixel_value = 32'(pix);
        r.done_res    = 1'(done);
        r.busy_res    = 1'(busy);
        r.accepted    = 1'(acc);
        return r;
    endfunction

    initial begin : stimulus
        t_row plan[$];
        int   phase_w [8];
        int   phase_h [8];
        phase_w = '{8191, 24, 0, 1, 37, 4096, 13, 300};
        phase_h = '{8191, 16, 50, 1, 5, 1, 0, 200};

        plan.push_back(plan_row(KIND_TICK, 0, 0, 0, 0, 0, 1, 1'b1, '0));
        plan.push_back(plan_row(KIND_FILL, 0, 0, 0, 5, 32'h1, 1, 1'b1, '0));
        plan.push_back(plan_row(KIND_FILL, 0, 0, 1, 1, 32'hFFFF_FFFF, 1, 1'b1,
                                known(0, 0, 0, 0, 1, 1)));
        // command while busy is dropped
        plan.push_back(plan_row(KIND_BLIT, -32768, 32767, -32768, 32767, 32'hFFFF_FFFF, 1,
                                1'b1, known(0, 0, 0, 0, 1, 0)));
        plan.push_back(plan_row(KIND_TICK, 0, 0, 0, 0, 0, 1, 1'b1,
                                known(1, 0, 32'hFFFF_FFFF, 1, 0, 0)));
        plan.push_back(plan_row(KIND_FILL, -32768, -32768, 32767, 32767, 32'h5, 1, 1'b1, '0));
        plan.push_back(plan_row(KIND_FILL, 639, 479, 32767, 32767, 32'h1234_5678, 1, 1'b1,
                                known(0, 0, 0, 0, 1, 1)));
        plan.push_back(plan_row(KIND_TICK, 0, 0, 0, 0, 0, 1, 1'b1,
                                known(1, 307199, 32'h1234_5678, 1, 0, 0)));
        plan.push_back(plan_row(KIND_FILL, 640, 0, 5, 5, 32'h7, 1, 1'b1, '0));
        plan.push_back(plan_row(KIND_BLIT, -3, -2, 5, 4, 0, 1, 1'b0, '0));
        plan.push_back(plan_row(KIND_TICK, 0, 0, 0, 0, 0, 4, 1'b0, '0));
        plan.push_back(plan_row(KIND_CURSOR, -11, -18, 0, 0, 0, 1, 1'b0, '0));
        plan.push_back(plan_row(KIND_TICK, 0, 0, 0, 0, 0, 228, 1'b0, '0));
        plan.push_back(plan_row(KIND_CURSOR, 639, 479, 0, 0, 0, 1, 1'b0, '0));
        plan.push_back(plan_row(KIND_TICK, 0, 0, 0, 0, 0, 228, 1'b0, '0));
        plan.push_back(plan_row(KIND_CURSOR, -12, 0, 0, 0, 0, 1, 1'b1, '0));
        plan.push_back(plan_row(KIND_BLIT, 0, 0, -5, 3, 0, 1, 1'b1, '0));
        plan.push_back(plan_row(KIND_BLIT, -32768, 0, 32767, 10, 0, 1, 1'b1, '0));
        plan.push_back(plan_row(KIND_FILL, 32767, 32767, 32767, 32767, 32'h0, 1, 1'b1, '0));
        plan.push_back(plan_row(KIND_CURSOR, 5, 5, 0, 0, 0, 1, 1'b0, '0));
        plan.push_back(plan_row(KIND_FILL, -1, -1, 3, 3, 32'hAAAA_5555, 1, 1'b1,
                                known(0, 0, 0, 0, 1, 0)));
        plan.push_back(plan_row(KIND_TICK, 0, 0, 0, 0, 0, 228, 1'b0, '0));
        plan.push_back(plan_row(KIND_TICK, -1, -1, -1, -1, 32'hFFFF_FFFF, 1, 1'b1, '0));
        // leave a fill running so the next width change lands mid-job
        plan.push_back(plan_row(KIND_FILL, 0, 0, 4, 2, 32'hA5A5_A5A5, 1, 1'b0, '0));
        plan.push_back(plan_row(KIND_TICK, 0, 0, 0, 0, 0, 3, 1'b0, '0));

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_pct = 37;
        recv_pct = 58;
        foreach (plan[i]) begin
            repeat (int'(plan[i].reps)) drive_req(plan[i].req, plan[i].fixed, plan[i].res);
        end

        for (int p = 0; p < 8; p++) begin
            if (p == 3) begin
                send_pct = 58;
                recv_pct = 37;
            end else if (p == 6) begin
                send_pct = 0;
                recv_pct = 0;
            end
            drain_results();
            write_surface(DIM_W'(phase_w[p]), DIM_W'(phase_h[p]));
            random_phase(80);
        end

        drain_results();
        if (mismatches == 0) begin
            $display("clipped_fill_blit_sprite_engine_top test passed");
        end else begin
            $display("clipped_fill_blit_sprite_engine_top test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("clipped_fill_blit_sprite_engine_top test failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/cfbse_pkg.sv
rtl/core/cfbse_front.sv
rtl/core/cfbse_queue.sv
rtl/core/cfbse_back.sv
rtl/core/clipped_fill_blit_sprite_engine_top.sv
tb/testbench.sv
